// ===== hw/rtl/abms_pkg.sv =====
// Package for the adjacency bit matrix store: field widths, request codes,
// register map and the command/status structs between controller and datapath.
// No dependencies.
package abms_pkg;

    localparam int TYPE_W  = 3;
    localparam int NODE_W  = 5;
    localparam int COUNT_W = 6;
    localparam int DEG_W   = 6;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int CIDX_W  = ADDR_W - 2;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 6'd32;
    localparam logic [CIDX_W-1:0]  REG_NODE_COUNT = 1'b0;

    localparam logic [TYPE_W-1:0] OP_ADD   = 3'd0;
    localparam logic [TYPE_W-1:0] OP_COUNT = 3'd1;
    localparam logic [TYPE_W-1:0] OP_LIST  = 3'd2;
    localparam logic [TYPE_W-1:0] OP_DEL   = 3'd3;
    localparam logic [TYPE_W-1:0] OP_TRANS = 3'd4;

    typedef enum logic [1:0] {RD_A, RD_I, RD_J} t_rd_sel;
    typedef enum logic [1:0] {WR_ADD, WR_DEL, WR_TI, WR_TJ} t_wr_kind;
    typedef enum logic [1:0] {EM_DONE, EM_DEG, EM_LIST} t_emit_kind;

    typedef struct packed {
        logic       latch_req;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_en;
        t_wr_kind   wr_kind;
        logic       ld_row;
        logic       ld_rowj;
        logic       swap;
        logic       part_ld;
        logic       i_clr;
        logic       i_inc;
        logic       i_from_j;
        logic       j_clr;
        logic       j_inc;
        logic       vclr;
        logic       emit;
        t_emit_kind emit_kind;
    } t_cmd;

    typedef struct packed {
        logic [TYPE_W-1:0] op;
        logic              err;
        logic              n_zero;
        logic              i_last;
        logic              j_last;
        logic              row_empty;
        logic              row_one;
        logic              out_free;
    } t_sts;

endpackage

// ===== hw/rtl/abms_if.sv =====
// Handshake channels of the adjacency bit matrix store: request and result.
// Depends on abms_pkg for the field widths.
interface abms_req_if;
    logic                         valid;
    logic                         ready;
    logic [abms_pkg::TYPE_W-1:0]  req_type;
    logic [abms_pkg::NODE_W-1:0]  node_a;
    logic [abms_pkg::NODE_W-1:0]  node_b;

    modport source(output valid, output req_type, output node_a, output node_b, input ready);
    modport sink(input valid, input req_type, input node_a, input node_b, output ready);
endinterface

interface abms_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [abms_pkg::DEG_W-1:0]   degree;
    logic [abms_pkg::NODE_W-1:0]  neighbor;
    logic                         neighbor_valid;
    logic                         last;

    modport source(output valid, output status, output degree, output neighbor,
                   output neighbor_valid, output last, input ready);
    modport sink(input valid, input status, input degree, input neighbor,
                 input neighbor_valid, input last, output ready);
endinterface

// ===== hw/rtl/abms_ctrl.sv =====
// Sequencer of the adjacency bit matrix store: walks each request through
// its row reads, writes and result emits. Depends on abms_pkg.
module abms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  abms_pkg::t_sts i_sts,
    output abms_pkg::t_cmd o_cmd
);
    import abms_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ROW   = 4'd2;
    localparam logic [3:0] S_CNT1  = 4'd3;
    localparam logic [3:0] S_CNT2  = 4'd4;
    localparam logic [3:0] S_LIST  = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [3:0] S_D_RD  = 4'd7;
    localparam logic [3:0] S_D_WR  = 4'd8;
    localparam logic [3:0] S_T_RDJ = 4'd9;
    localparam logic [3:0] S_T_LDJ = 4'd10;
    localparam logic [3:0] S_T_RDI = 4'd11;
    localparam logic [3:0] S_T_WRI = 4'd12;
    localparam logic [3:0] S_T_WRJ = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.rd_sel    = RD_A;
        o_cmd.wr_kind   = WR_ADD;
        o_cmd.emit_kind = EM_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.op > OP_TRANS) begin
                    n_state = S_DONE;
                end else if (i_sts.op == OP_TRANS) begin
                    if (i_sts.n_zero) begin
                        // no node in use: drop every row
                        o_cmd.vclr = 1'b1;
                        n_state    = S_DONE;
                    end else begin
                        o_cmd.vclr  = 1'b1;
                        o_cmd.j_clr = 1'b1;
                        n_state     = S_T_RDJ;
                    end
                end else if (i_sts.err) begin
                    n_state = S_DONE;
                end else if (i_sts.op == OP_DEL) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = S_D_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_A;
                    n_state      = S_ROW;
                end
            end
            S_ROW: begin
                priority if (i_sts.op == OP_ADD) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_kind = WR_ADD;
                    n_state       = S_DONE;
                end else if (i_sts.op == OP_COUNT) begin
                    o_cmd.ld_row = 1'b1;
                    n_state      = S_CNT1;
                end else begin
                    o_cmd.ld_row = 1'b1;
                    n_state      = S_LIST;
                end
            end
            S_CNT1: begin
                o_cmd.part_ld = 1'b1;
                n_state       = S_CNT2;
            end
            S_CNT2: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_DEG;
                    n_state         = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_LIST;
                    if (i_sts.row_empty || i_sts.row_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_DONE;
                    n_state         = S_IDLE;
                end
            end
            S_D_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_I;
                n_state      = S_D_WR;
            end
            S_D_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_kind = WR_DEL;
                if (i_sts.i_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_D_RD;
                end
            end
            S_T_RDJ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_J;
                n_state      = S_T_LDJ;
            end
            S_T_LDJ: begin
                o_cmd.ld_rowj  = 1'b1;
                o_cmd.i_from_j = 1'b1;
                n_state        = i_sts.j_last ? S_T_WRJ : S_T_RDI;
            end
            S_T_RDI: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_I;
                n_state      = S_T_WRI;
            end
            S_T_WRI: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_kind = WR_TI;
                o_cmd.swap    = 1'b1;
                if (i_sts.i_last) begin
                    n_state = S_T_WRJ;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_T_RDI;
                end
            end
            S_T_WRJ: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_kind = WR_TJ;
                if (i_sts.j_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_T_RDJ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/abms_dpath.sv =====
// Datapath of the adjacency bit matrix store: row memory with per-row valid
// bits, row working register, counters and result register. Depends on abms_pkg.
module abms_dpath #(
    parameter int MAX_NODES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  abms_pkg::t_cmd                i_cmd,
    output abms_pkg::t_sts                o_sts,
    input  logic [abms_pkg::COUNT_W-1:0]  i_node_count,
    input  logic [abms_pkg::TYPE_W-1:0]   i_req_type,
    input  logic [abms_pkg::NODE_W-1:0]   i_node_a,
    input  logic [abms_pkg::NODE_W-1:0]   i_node_b,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic                          o_status,
    output logic [abms_pkg::DEG_W-1:0]    o_degree,
    output logic [abms_pkg::NODE_W-1:0]   o_neighbor,
    output logic                          o_neighbor_valid,
    output logic                          o_last
);
    import abms_pkg::*;

    localparam int AW  = $clog2(MAX_NODES);
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int NCH = (MAX_NODES + 7) / 8;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            c = c + 4'(v[k]);
        end
        return c;
    endfunction

    // request fields, held for the whole request
    logic [TYPE_W-1:0]    r_op;
    logic [NODE_W-1:0]    r_a;
    logic [NODE_W-1:0]    r_b;

    logic [AW-1:0]        r_i;
    logic [AW-1:0]        r_j;
    logic [MAX_NODES-1:0] r_row;
    logic [3:0]           r_part [NCH];

    logic [MAX_NODES-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_rdata;
    logic                 r_rvld;
    logic [MAX_NODES-1:0] r_vld;

    logic [NW-1:0]        n;
    logic [MAX_NODES-1:0] cm;
    logic [AW-1:0]        a_idx;
    logic [MAX_NODES-1:0] bit_a;
    logic [MAX_NODES-1:0] bit_b;
    logic [MAX_NODES-1:0] rdat;
    logic [MAX_NODES-1:0] low;
    logic [AW-1:0]        low_idx;
    logic [NW-1:0]        deg;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [MAX_NODES-1:0] wdata;
    logic [NCH*8-1:0]     row_pad;
    logic                 out_free;

    always_comb begin
        if (int'(i_node_count) > MAX_NODES) begin
            n = NW'(MAX_NODES);
        end else begin
            n = NW'(i_node_count);
        end
        for (int k = 0; k < MAX_NODES; k++) begin
            cm[k] = (k < int'(n));
        end
    end

    assign a_idx = AW'(r_a);
    assign bit_a = MAX_NODES'(1) << a_idx;
    assign bit_b = MAX_NODES'(1) << r_b;
    assign rdat  = r_rvld ? r_rdata : '0;

    // lowest successor still to be listed
    assign low = r_row & (~r_row + MAX_NODES'(1));
    always_comb begin
        low_idx = '0;
        for (int k = 0; k < MAX_NODES; k++) begin
            if (low[k]) begin
                low_idx = low_idx | AW'(k);
            end
        end
    end

    always_comb begin
        deg = '0;
        for (int k = 0; k < NCH; k++) begin
            deg = deg + NW'(r_part[k]);
        end
    end

    assign row_pad  = (NCH * 8)'(r_row);
    assign out_free = !o_rsp_valid || i_rsp_ready;

    always_comb begin
        o_sts.op        = r_op;
        o_sts.err       = (r_op <= OP_DEL) &&
                          ((int'(r_a) >= int'(n)) ||
                           ((r_op == OP_ADD) && (int'(r_b) >= int'(n))));
        o_sts.n_zero    = (n == '0);
        o_sts.i_last    = (int'(r_i) == int'(n) - 1);
        o_sts.j_last    = (int'(r_j) == int'(n) - 1);
        o_sts.row_empty = (r_row == '0);
        o_sts.row_one   = ((r_row & (r_row - MAX_NODES'(1))) == '0);
        o_sts.out_free  = out_free;
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_A:    raddr = a_idx;
            RD_I:    raddr = r_i;
            RD_J:    raddr = r_j;
            default: raddr = a_idx;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_kind)
            WR_ADD: begin
                waddr = a_idx;
                wdata = rdat | bit_b;
            end
            WR_DEL: begin
                waddr = r_i;
                wdata = (r_i == a_idx) ? (rdat & ~cm & ~bit_a) : (rdat & ~bit_a);
            end
            WR_TI: begin
                waddr        = r_i;
                wdata        = rdat;
                wdata[r_j]   = r_row[r_i];
            end
            WR_TJ: begin
                waddr = r_j;
                wdata = r_row & cm;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    // a row that is not valid reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_cmd.vclr) begin
                for (int k = 0; k < MAX_NODES; k++) begin
                    if (k >= int'(n)) begin
                        r_vld[k] <= 1'b0;
                    end
                end
            end else if (i_cmd.wr_en) begin
                r_vld[waddr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rvld <= r_vld[raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_op <= i_req_type;
            r_a  <= i_node_a;
            r_b  <= i_node_b;
        end
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_from_j) begin
            r_i <= r_j + AW'(1);
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + AW'(1);
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + AW'(1);
        end
        if (i_cmd.ld_row) begin
            r_row <= rdat & cm;
        end else if (i_cmd.ld_rowj) begin
            r_row <= rdat;
        end else if (i_cmd.swap) begin
            r_row[r_i] <= rdat[r_j];
        end else if (i_cmd.emit && (i_cmd.emit_kind == EM_LIST)) begin
            r_row <= r_row & (r_row - MAX_NODES'(1));
        end
        if (i_cmd.part_ld) begin
            for (int k = 0; k < NCH; k++) begin
                r_part[k] <= popcount8(row_pad[k*8 +: 8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            o_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status         <= 1'b0;
            o_degree         <= '0;
            o_neighbor       <= '0;
            o_neighbor_valid <= 1'b0;
            o_last           <= 1'b1;
            unique case (i_cmd.emit_kind)
                EM_DONE: begin
                    o_status <= o_sts.err;
                end
                EM_DEG: begin
                    o_degree <= DEG_W'(deg);
                end
                EM_LIST: begin
                    if (r_row != '0) begin
                        o_neighbor       <= NODE_W'(low_idx);
                        o_neighbor_valid <= 1'b1;
                        o_last           <= o_sts.row_one;
                    end
                end
                default: begin
                    o_status <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/adjacency_bit_matrix_store_top.sv =====
// Top level of the adjacency bit matrix store: APB register, controller and
// datapath. Depends on abms_pkg, abms_if, abms_ctrl and abms_dpath.
//
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   req_type[2:0], node_a[4:0], node_b[4:0]
//  o_rsp     out  valid/ready   status, degree[5:0], neighbor[4:0], neighbor_valid, last
//  APB       in   psel/penable  paddr[2:0], pwdata[31:0] -> node_count at 0x0
//
// One request at a time; the memory port does one row read or write per
// cycle. Delete walks every row in use, transpose walks the rows in use
// pairwise, and list emits one result item per successor (one item when
// there are no successors).
// Reset is synchronous; the row valid bits clear at once, no clearing pass.
// A stalled result holds in the output register and the sequencer waits.
module adjacency_bit_matrix_store_top #(
    parameter int MAX_NODES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    abms_req_if.sink                     i_req,
    abms_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [abms_pkg::ADDR_W-1:0]  paddr,
    input  logic [abms_pkg::DATA_W-1:0]  pwdata,
    output logic [abms_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import abms_pkg::*;

    logic [COUNT_W-1:0] r_node_count;
    logic [CIDX_W-1:0]  cfg_idx;
    t_cmd               cmd;
    t_sts               sts;
    logic               req_ready;

    // Register file: a single register, node_count, at byte address zero.
    // Writes land in the access phase; pready never stalls.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign prdata  = (cfg_idx == REG_NODE_COUNT) ? DATA_W'(r_node_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (psel && penable && pwrite && pready &&
                     (cfg_idx == REG_NODE_COUNT)) begin
            r_node_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign i_req.ready = req_ready;

    // The sequencer steps a request through its row accesses.
    abms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Row memory, working row and result register.
    abms_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_node_count     (r_node_count),
        .i_req_type       (i_req.req_type),
        .i_node_a         (i_req.node_a),
        .i_node_b         (i_req.node_b),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_degree         (o_rsp.degree),
        .o_neighbor       (o_rsp.neighbor),
        .o_neighbor_valid (o_rsp.neighbor_valid),
        .o_last           (o_rsp.last)
    );

endmodule
